// ===== sv/rsat_pkg.sv =====
// ----------------------------------------------------------------------------
// rsat_pkg
// Shared types, codes and constants of the region subscription and
// acknowledge tracker.
// ----------------------------------------------------------------------------
package rsat_pkg;

    localparam int unsigned DEF_MAX_BLOCKS      = 1024;
    localparam int unsigned DEF_PENDING_ENTRIES = 16;
    localparam int unsigned DEF_BLOCK_SHIFT     = 20;
    localparam int unsigned QUEUE_DEPTH         = 2;

    localparam int unsigned ADDR_W      = 48;
    localparam int unsigned NODE_W      = 6;
    localparam int unsigned COMP_W      = 4;
    localparam int unsigned ACK_W       = 4;
    localparam int unsigned BLK_FIELD_W = 16;
    localparam int unsigned PADDR_W     = 6;
    localparam int unsigned PDATA_W     = 64;

    localparam logic [2:0] OP_INIT         = 3'd0;
    localparam logic [2:0] OP_SHARED_REQ   = 3'd1;
    localparam logic [2:0] OP_ATOMIC_REQ   = 3'd2;
    localparam logic [2:0] OP_ATOMIC_REPLY = 3'd3;
    localparam logic [2:0] OP_ATOMIC_MSG   = 3'd4;
    localparam logic [2:0] OP_INVAL_REPLY  = 3'd5;

    localparam logic [2:0] KIND_CORE_DONE    = 3'd0;
    localparam logic [2:0] KIND_TLB_INSERT   = 3'd1;
    localparam logic [2:0] KIND_ATOMIC_MSG   = 3'd2;
    localparam logic [2:0] KIND_INVAL_REQ    = 3'd3;
    localparam logic [2:0] KIND_ATOMIC_REPLY = 3'd4;
    localparam logic [2:0] KIND_USER_DONE    = 3'd5;

    localparam logic [COMP_W-1:0] COMP_CORE = 4'd0;
    localparam logic [COMP_W-1:0] COMP_LLC  = 4'd1;
    localparam logic [COMP_W-1:0] COMP_GMM  = 4'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_OOR  = 2'd1;
    localparam logic [1:0] STATUS_FULL = 2'd2;

    localparam logic [2:0] REG_NODE_ID      = 3'd0;
    localparam logic [2:0] REG_REGION_START = 3'd1;
    localparam logic [2:0] REG_REGION_END   = 3'd2;
    localparam logic [2:0] REG_REPLY_NODE   = 3'd3;
    localparam logic [2:0] REG_ACK_COUNT    = 3'd4;

    localparam logic [NODE_W-1:0] REPLY_NODE_RESET = 6'd8;
    localparam logic [ACK_W-1:0]  ACK_COUNT_RESET  = 4'd2;

    typedef struct packed {
        logic [NODE_W-1:0] node_id;
        logic [ADDR_W-1:0] region_start;
        logic [ADDR_W-1:0] region_end;
        logic [NODE_W-1:0] reply_node;
        logic [ACK_W-1:0]  ack_count;
    } t_cfg;

    typedef struct packed {
        logic [2:0]             op;
        logic [NODE_W-1:0]      req;
        logic [NODE_W-1:0]      recv;
        logic [COMP_W-1:0]      comp;
        logic [ADDR_W-1:0]      a;
        logic [ADDR_W-1:0]      b;
        logic                   oor;
        logic [BLK_FIELD_W-1:0] blk;
        logic [ADDR_W-1:0]      lo;
        logic [ADDR_W-1:0]      hi;
    } t_item;

    typedef struct packed {
        logic [2:0]        kind;
        logic [COMP_W-1:0] comp;
        logic [NODE_W-1:0] recv;
        logic [NODE_W-1:0] req;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        logic [1:0]        status;
        logic              last;
    } t_result;

    typedef enum logic [1:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_LOOKUP,
        BS_EMIT2
    } t_bstate;

endpackage

// ===== sv/rsat_front.sv =====
// ----------------------------------------------------------------------------
// rsat_front
// Accepts input transactions, checks the address against the region and
// precomputes block index and clipped insert range.
// ----------------------------------------------------------------------------
module rsat_front
    import rsat_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS  = DEF_MAX_BLOCKS,
    parameter int unsigned BLOCK_SHIFT = DEF_BLOCK_SHIFT
) (
    input  logic              i_in_valid,
    input  logic [2:0]        i_opcode,
    input  logic [NODE_W-1:0] i_requester,
    input  logic [NODE_W-1:0] i_receiver,
    input  logic [COMP_W-1:0] i_component,
    input  logic [ADDR_W-1:0] i_payload_a,
    input  logic [ADDR_W-1:0] i_payload_b,
    input  t_cfg              i_cfg,
    input  logic              i_q_full,
    input  logic              i_hold,
    output logic              o_in_stall,
    output logic              o_push,
    output t_item             o_item
);

    logic [ADDR_W-1:0] a_blk;
    logic [ADDR_W-1:0] s_blk;
    logic [ADDR_W-1:0] diff;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W:0]   hi_ext;

    always_comb begin
        a_blk  = i_payload_a >> BLOCK_SHIFT;
        s_blk  = i_cfg.region_start >> BLOCK_SHIFT;
        diff   = a_blk - s_blk;
        base   = a_blk << BLOCK_SHIFT;
        hi_ext = {1'b0, base} + ((ADDR_W+1)'(1) << BLOCK_SHIFT);

        o_item.op   = i_opcode;
        o_item.req  = i_requester;
        o_item.recv = i_receiver;
        o_item.comp = i_component;
        o_item.a    = i_payload_a;
        o_item.b    = i_payload_b;
        o_item.oor  = (i_payload_a < i_cfg.region_start) ||
                      (i_payload_a >= i_cfg.region_end) ||
                      (diff >= ADDR_W'(MAX_BLOCKS));
        o_item.blk  = diff[BLK_FIELD_W-1:0];
        o_item.lo   = (base > i_cfg.region_start) ? base : i_cfg.region_start;
        o_item.hi   = (hi_ext > {1'b0, i_cfg.region_end}) ? i_cfg.region_end
                                                          : hi_ext[ADDR_W-1:0];
    end

    assign o_in_stall = i_q_full || i_hold;
    assign o_push     = i_in_valid && !o_in_stall;

endmodule

// ===== sv/rsat_queue.sv =====
// ----------------------------------------------------------------------------
// rsat_queue
// Short first-in first-out queue of classified transactions between the
// front and the back.
// ----------------------------------------------------------------------------
module rsat_queue
    import rsat_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item,
    output logic  o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;

    function automatic logic [PTR_W-1:0] f_inc(input logic [PTR_W-1:0] p);
        f_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= f_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= f_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_item  = r_mem[r_rp];

endmodule

// ===== sv/rsat_back.sv =====
// ----------------------------------------------------------------------------
// rsat_back
// Carries out queued transactions: subscription map read-modify-write and
// clearing sweep, pending table allocate and acknowledge, result register.
// ----------------------------------------------------------------------------
module rsat_back
    import rsat_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS      = DEF_MAX_BLOCKS,
    parameter int unsigned PENDING_ENTRIES = DEF_PENDING_ENTRIES
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_q_valid,
    input  t_item   i_q_item,
    output logic    o_pop,
    output logic    o_clearing,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_result o_result
);

    localparam int unsigned BLK_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int unsigned PE_W  = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;

    t_bstate r_state, n_state;
    t_item   r_cur;
    logic [BLK_W-1:0] r_clr;

    logic              r_map [MAX_BLOCKS];
    logic              r_rd;
    logic              mem_we, mem_wd, mem_re;
    logic [BLK_W-1:0]  mem_wa, mem_ra;

    logic              r_pv [PENDING_ENTRIES];
    logic [ADDR_W-1:0] r_pa [PENDING_ENTRIES];
    logic [ACK_W-1:0]  r_pc [PENDING_ENTRIES];

    logic              r_out_valid;
    t_result           r_out, n_out;
    logic              out_load, can_load;

    logic              any_free, any_match;
    logic [PE_W-1:0]   free_idx, match_idx;
    logic              alloc, dec;
    logic [ACK_W-1:0]  ack_init;

    function automatic t_result f_res(input logic [2:0] kind,
                                      input logic [COMP_W-1:0] comp,
                                      input logic [NODE_W-1:0] recv,
                                      input logic [NODE_W-1:0] req,
                                      input logic [ADDR_W-1:0] a,
                                      input logic [ADDR_W-1:0] b,
                                      input logic [1:0] st,
                                      input logic lst);
        t_result r;
        r.kind   = kind;
        r.comp   = comp;
        r.recv   = recv;
        r.req    = req;
        r.a      = a;
        r.b      = b;
        r.status = st;
        r.last   = lst;
        return r;
    endfunction

    function automatic t_result f_done(input t_item it, input logic [1:0] st);
        return f_res(KIND_CORE_DONE, it.comp, it.recv, it.req, it.a, it.b, st, 1'b1);
    endfunction

    always_comb begin
        any_free  = 1'b0;
        any_match = 1'b0;
        free_idx  = '0;
        match_idx = '0;
        for (int i = PENDING_ENTRIES - 1; i >= 0; i--) begin
            if (!r_pv[i]) begin
                any_free = 1'b1;
                free_idx = PE_W'(i);
            end
            if (r_pv[i] && (r_pa[i] == i_q_item.a)) begin
                any_match = 1'b1;
                match_idx = PE_W'(i);
            end
        end
    end

    assign can_load = !r_out_valid || !i_out_stall;
    assign ack_init = (i_cfg.ack_count == '0) ? ACK_W'(1) : i_cfg.ack_count;

    always_comb begin
        n_state  = r_state;
        o_pop    = 1'b0;
        out_load = 1'b0;
        n_out    = f_done(i_q_item, STATUS_OK);
        mem_we   = 1'b0;
        mem_wd   = 1'b0;
        mem_wa   = r_clr;
        mem_re   = 1'b0;
        mem_ra   = i_q_item.blk[BLK_W-1:0];
        alloc    = 1'b0;
        dec      = 1'b0;
        case (r_state)
            BS_CLEAR: begin
                mem_we = 1'b1;
                if (r_clr == BLK_W'(MAX_BLOCKS - 1)) begin
                    n_state = BS_IDLE;
                end
            end
            BS_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_item.op)
                        OP_SHARED_REQ: begin
                            if (i_q_item.oor) begin
                                if (can_load) begin
                                    o_pop    = 1'b1;
                                    out_load = 1'b1;
                                    n_out    = f_done(i_q_item, STATUS_OOR);
                                end
                            end else begin
                                o_pop   = 1'b1;
                                mem_re  = 1'b1;
                                n_state = BS_LOOKUP;
                            end
                        end
                        OP_INIT: begin
                            if (can_load) begin
                                o_pop    = 1'b1;
                                out_load = 1'b1;
                                n_state  = BS_CLEAR;
                            end
                        end
                        OP_ATOMIC_REQ: begin
                            if (can_load) begin
                                o_pop    = 1'b1;
                                out_load = 1'b1;
                                if (!any_free) begin
                                    n_out = f_done(i_q_item, STATUS_FULL);
                                end else begin
                                    alloc   = 1'b1;
                                    n_out   = f_res(KIND_ATOMIC_MSG, COMP_GMM, i_q_item.recv,
                                                    i_q_item.req, i_q_item.a, i_q_item.b,
                                                    STATUS_OK, 1'b0);
                                    n_state = BS_EMIT2;
                                end
                            end
                        end
                        OP_ATOMIC_REPLY: begin
                            if (can_load) begin
                                o_pop    = 1'b1;
                                out_load = 1'b1;
                                if (any_match) begin
                                    dec = 1'b1;
                                    if (r_pc[match_idx] == ACK_W'(1)) begin
                                        n_out = f_res(KIND_USER_DONE, COMP_CORE, i_q_item.req,
                                                      i_q_item.req, i_q_item.a, i_q_item.b,
                                                      STATUS_OK, 1'b1);
                                    end
                                end
                            end
                        end
                        OP_ATOMIC_MSG: begin
                            if (can_load) begin
                                o_pop    = 1'b1;
                                out_load = 1'b1;
                                n_out    = f_res(KIND_INVAL_REQ, COMP_LLC, i_cfg.node_id,
                                                 i_q_item.req, i_q_item.a, i_q_item.b,
                                                 STATUS_OK, 1'b1);
                            end
                        end
                        OP_INVAL_REPLY: begin
                            if (can_load) begin
                                o_pop    = 1'b1;
                                out_load = 1'b1;
                                n_out    = f_res(KIND_ATOMIC_REPLY, COMP_GMM, i_cfg.reply_node,
                                                 i_q_item.req, i_q_item.a, i_q_item.b,
                                                 STATUS_OK, 1'b1);
                            end
                        end
                        default: begin
                            if (can_load) begin
                                o_pop    = 1'b1;
                                out_load = 1'b1;
                            end
                        end
                    endcase
                end
            end
            BS_LOOKUP: begin
                if (r_rd) begin
                    n_state = BS_IDLE;
                end else if (can_load) begin
                    mem_we   = 1'b1;
                    mem_wd   = 1'b1;
                    mem_wa   = r_cur.blk[BLK_W-1:0];
                    out_load = 1'b1;
                    n_out    = f_res(KIND_TLB_INSERT, COMP_GMM, i_cfg.node_id, r_cur.req,
                                     r_cur.lo, r_cur.hi, STATUS_OK, 1'b1);
                    n_state  = BS_IDLE;
                end
            end
            BS_EMIT2: begin
                if (can_load) begin
                    out_load = 1'b1;
                    n_out    = f_res(KIND_INVAL_REQ, COMP_LLC, i_cfg.node_id, r_cur.req,
                                     r_cur.a, r_cur.b, STATUS_OK, 1'b1);
                    n_state  = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || r_state != BS_CLEAR) begin
            r_clr <= '0;
        end else begin
            r_clr <= r_clr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_q_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_map[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PENDING_ENTRIES; i++) begin
                r_pv[i] <= 1'b0;
            end
        end else if (alloc) begin
            r_pv[free_idx] <= 1'b1;
        end else if (dec && r_pc[match_idx] == ACK_W'(1)) begin
            r_pv[match_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (alloc) begin
            r_pa[free_idx] <= i_q_item.a;
            r_pc[free_idx] <= ack_init;
        end else if (dec) begin
            r_pc[match_idx] <= r_pc[match_idx] - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_clearing  = (r_state == BS_CLEAR);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

// ===== sv/region_subscription_and_ack_tracker_top.sv =====
// ----------------------------------------------------------------------------
// region_subscription_and_ack_tracker_top
// Memory-policy message engine: region subscription map, pending atomic
// update table with acknowledge counting, configuration registers.
// ----------------------------------------------------------------------------
// The front checks the region combinationally, the queue registers each item and the
// back-end result register holds the output; a shared request also reads the map.
// The single back-end sequencer works on one transaction at a time and waits
// on an output stall; an atomic request gives two results, one after the other.
// Init and reset start a clearing pass over the map, accepting nothing meanwhile.
// Reset is synchronous and active low; configuration returns to reset values.
module region_subscription_and_ack_tracker_top
    import rsat_pkg::*;
#(
    parameter int unsigned MAX_BLOCKS      = DEF_MAX_BLOCKS,
    parameter int unsigned PENDING_ENTRIES = DEF_PENDING_ENTRIES,
    parameter int unsigned BLOCK_SHIFT     = DEF_BLOCK_SHIFT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_opcode,
    input  logic [NODE_W-1:0]  i_requester,
    input  logic [NODE_W-1:0]  i_receiver,
    input  logic [COMP_W-1:0]  i_component,
    input  logic [ADDR_W-1:0]  i_payload_a,
    input  logic [ADDR_W-1:0]  i_payload_b,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_msg_kind,
    output logic [COMP_W-1:0]  o_out_component,
    output logic [NODE_W-1:0]  o_out_receiver,
    output logic [NODE_W-1:0]  o_out_requester,
    output logic [ADDR_W-1:0]  o_out_payload_a,
    output logic [ADDR_W-1:0]  o_out_payload_b,
    output logic [1:0]         o_status,
    output logic               o_last
);

    t_cfg    r_cfg;
    t_item   f_item, q_item;
    t_result res;
    logic    push, pop, q_valid, q_full, clearing;
    logic    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_id      <= '0;
            r_cfg.region_start <= '0;
            r_cfg.region_end   <= '0;
            r_cfg.reply_node   <= REPLY_NODE_RESET;
            r_cfg.ack_count    <= ACK_COUNT_RESET;
        end else if (wr_en) begin
            case (paddr[5:3])
                REG_NODE_ID:      r_cfg.node_id      <= pwdata[NODE_W-1:0];
                REG_REGION_START: r_cfg.region_start <= pwdata[ADDR_W-1:0];
                REG_REGION_END:   r_cfg.region_end   <= pwdata[ADDR_W-1:0];
                REG_REPLY_NODE:   r_cfg.reply_node   <= pwdata[NODE_W-1:0];
                REG_ACK_COUNT:    r_cfg.ack_count    <= pwdata[ACK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_NODE_ID:      prdata = PDATA_W'(r_cfg.node_id);
            REG_REGION_START: prdata = PDATA_W'(r_cfg.region_start);
            REG_REGION_END:   prdata = PDATA_W'(r_cfg.region_end);
            REG_REPLY_NODE:   prdata = PDATA_W'(r_cfg.reply_node);
            REG_ACK_COUNT:    prdata = PDATA_W'(r_cfg.ack_count);
            default:          prdata = '0;
        endcase
    end

    rsat_front #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .BLOCK_SHIFT (BLOCK_SHIFT)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_opcode),
        .i_requester (i_requester),
        .i_receiver  (i_receiver),
        .i_component (i_component),
        .i_payload_a (i_payload_a),
        .i_payload_b (i_payload_b),
        .i_cfg       (r_cfg),
        .i_q_full    (q_full),
        .i_hold      (clearing),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_item      (f_item)
    );

    rsat_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_full  (q_full)
    );

    rsat_back #(
        .MAX_BLOCKS      (MAX_BLOCKS),
        .PENDING_ENTRIES (PENDING_ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .o_clearing  (clearing),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_result    (res)
    );

    assign o_msg_kind      = res.kind;
    assign o_out_component = res.comp;
    assign o_out_receiver  = res.recv;
    assign o_out_requester = res.req;
    assign o_out_payload_a = res.a;
    assign o_out_payload_b = res.b;
    assign o_status        = res.status;
    assign o_last          = res.last;

endmodule

// ===== sv/rsat_checker.sv =====
// ----------------------------------------------------------------------------
// rsat_checker
// Port-level checks of the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module rsat_checker
    import rsat_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_msg_kind,
    input logic [1:0]  o_status,
    input logic        o_last
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_msg_kind))
        else $error("stalled result changed");

    a_first_of_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_msg_kind == KIND_ATOMIC_MSG |-> !o_last)
        else $error("atomic message marked last");

    a_error_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STATUS_OK |->
            o_msg_kind == KIND_CORE_DONE && o_last)
        else $error("error status on wrong result");

endmodule

bind region_subscription_and_ack_tracker_top rsat_checker u_chk (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the region subscription and acknowledge tracker.
// Writes the registers over APB between phases, drives directed and random
// control messages with random idling on both sides, predicts every outgoing
// message and compares each one field by field as it leaves the block.
// ----------------------------------------------------------------------------
module testbench
    import rsat_pkg::*;
();

    localparam logic [2:0] OP_OTHER = 3'd6;
    localparam logic [2:0] OP_SPARE = 3'd7;
    localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [2:0]        op;
        logic [NODE_W-1:0] req;
        logic [NODE_W-1:0] recv;
        logic [COMP_W-1:0] comp;
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
    } t_msg;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [2:0]         i_opcode;
    logic [NODE_W-1:0]  i_requester, i_receiver;
    logic [COMP_W-1:0]  i_component;
    logic [ADDR_W-1:0]  i_payload_a, i_payload_b;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [2:0]         o_msg_kind;
    logic [COMP_W-1:0]  o_out_component;
    logic [NODE_W-1:0]  o_out_receiver, o_out_requester;
    logic [ADDR_W-1:0]  o_out_payload_a, o_out_payload_b;
    logic [1:0]         o_status;
    logic               o_last;

    region_subscription_and_ack_tracker_top i_dut (.*);

    t_msg    msg_q[$];
    t_result outbound_q[$];
    int      fail_cnt;
    bit      in_taken;
    bit      no_idle;
    int      in_gap, out_gap;

    // model state
    t_cfg              cfg;
    bit                sub_map[DEF_MAX_BLOCKS];
    bit                pend_vld[DEF_PENDING_ENTRIES];
    logic [ADDR_W-1:0] pend_addr[DEF_PENDING_ENTRIES];
    logic [ACK_W-1:0]  pend_cnt[DEF_PENDING_ENTRIES];
    logic [ADDR_W-1:0] atom_pool[4];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    function automatic logic [ADDR_W-1:0] rand48();
        return {$urandom, $urandom} & MASK48;
    endfunction

    task automatic predict_msgs(input t_msg m);
        t_result     r;
        logic [63:0] blk, base, lo, hi;
        int          idx;
        r = '{KIND_CORE_DONE, m.comp, m.recv, m.req, m.a, m.b, STATUS_OK, 1'b1};
        case (m.op)
            OP_INIT: begin
                foreach (sub_map[k]) sub_map[k] = 1'b0;
                outbound_q.push_back(r);
            end
            OP_SHARED_REQ: begin
                blk = (64'(m.a) >> DEF_BLOCK_SHIFT) - (64'(cfg.region_start) >> DEF_BLOCK_SHIFT);
                if (m.a < cfg.region_start || m.a >= cfg.region_end || blk >= DEF_MAX_BLOCKS) begin
                    r.status = STATUS_OOR;
                    outbound_q.push_back(r);
                end else if (!sub_map[blk]) begin
                    sub_map[blk] = 1'b1;
                    base = (64'(m.a) >> DEF_BLOCK_SHIFT) << DEF_BLOCK_SHIFT;
                    lo = (base > cfg.region_start) ? base : 64'(cfg.region_start);
                    hi = base + (64'd1 << DEF_BLOCK_SHIFT);
                    if (hi > cfg.region_end) hi = cfg.region_end;
                    outbound_q.push_back('{KIND_TLB_INSERT, COMP_GMM, cfg.node_id, m.req,
                                           lo[47:0], hi[47:0], STATUS_OK, 1'b1});
                end
            end
            OP_ATOMIC_REQ: begin
                idx = -1;
                for (int k = DEF_PENDING_ENTRIES - 1; k >= 0; k--)
                    if (!pend_vld[k]) idx = k;
                if (idx < 0) begin
                    r.status = STATUS_FULL;
                    outbound_q.push_back(r);
                end else begin
                    pend_vld[idx] = 1'b1;
                    pend_addr[idx] = m.a;
                    pend_cnt[idx] = (cfg.ack_count == 0) ? 4'd1 : cfg.ack_count;
                    outbound_q.push_back('{KIND_ATOMIC_MSG, COMP_GMM, m.recv, m.req,
                                           m.a, m.b, STATUS_OK, 1'b0});
                    outbound_q.push_back('{KIND_INVAL_REQ, COMP_LLC, cfg.node_id, m.req,
                                           m.a, m.b, STATUS_OK, 1'b1});
                end
            end
            OP_ATOMIC_REPLY: begin
                idx = -1;
                for (int k = DEF_PENDING_ENTRIES - 1; k >= 0; k--)
                    if (pend_vld[k] && pend_addr[k] == m.a) idx = k;
                if (idx >= 0) begin
                    pend_cnt[idx] = pend_cnt[idx] - 4'd1;
                    if (pend_cnt[idx] == 0) begin
                        pend_vld[idx] = 1'b0;
                        r = '{KIND_USER_DONE, COMP_CORE, m.req, m.req, m.a, m.b, STATUS_OK, 1'b1};
                    end
                end
                outbound_q.push_back(r);
            end
            OP_ATOMIC_MSG:
                outbound_q.push_back('{KIND_INVAL_REQ, COMP_LLC, cfg.node_id, m.req,
                                       m.a, m.b, STATUS_OK, 1'b1});
            OP_INVAL_REPLY:
                outbound_q.push_back('{KIND_ATOMIC_REPLY, COMP_GMM, cfg.reply_node, m.req,
                                       m.a, m.b, STATUS_OK, 1'b1});
            default: outbound_q.push_back(r);
        endcase
    endtask

    // driver
    always @(negedge i_clk) begin
        t_msg m;
        bit   v;
        v = i_in_valid;
        m = '{i_opcode, i_requester, i_receiver, i_component, i_payload_a, i_payload_b};
        if (!i_in_valid || in_taken) begin
            v = 1'b0;
            if (in_gap > 0) begin
                in_gap--;
            end else if (msg_q.size() > 0) begin
                m = msg_q.pop_front();
                v = 1'b1;
                in_gap = pick_gap();
            end
        end
        i_in_valid  <= v;
        i_opcode    <= m.op;
        i_requester <= m.req;
        i_receiver  <= m.recv;
        i_component <= m.comp;
        i_payload_a <= m.a;
        i_payload_b <= m.b;
        if (out_gap > 0) begin
            out_gap--;
            i_out_stall <= 1'b1;
        end else begin
            out_gap = pick_gap();
            i_out_stall <= (out_gap > 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result e;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n && i_in_valid && !o_in_stall)
            predict_msgs('{i_opcode, i_requester, i_receiver, i_component,
                           i_payload_a, i_payload_b});
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (outbound_q.size() == 0) begin
                $error("unexpected transaction kind %0d", o_msg_kind);
                fail_cnt++;
            end else begin
                e = outbound_q.pop_front();
                if (o_msg_kind !== e.kind) begin
                    $error("msg_kind exp %0d got %0d", e.kind, o_msg_kind); fail_cnt++;
                end
                if (o_out_component !== e.comp) begin
                    $error("out_component exp %0d got %0d", e.comp, o_out_component); fail_cnt++;
                end
                if (o_out_receiver !== e.recv) begin
                    $error("out_receiver exp %0d got %0d", e.recv, o_out_receiver); fail_cnt++;
                end
                if (o_out_requester !== e.req) begin
                    $error("out_requester exp %0d got %0d", e.req, o_out_requester); fail_cnt++;
                end
                if (o_out_payload_a !== e.a) begin
                    $error("out_payload_a exp %h got %h", e.a, o_out_payload_a); fail_cnt++;
                end
                if (o_out_payload_b !== e.b) begin
                    $error("out_payload_b exp %h got %h", e.b, o_out_payload_b); fail_cnt++;
                end
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); fail_cnt++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_last); fail_cnt++;
                end
            end
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge i_clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = PADDR_W'(idx) << 3; pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_NODE_ID:      cfg.node_id = val[NODE_W-1:0];
            REG_REGION_START: cfg.region_start = val[ADDR_W-1:0];
            REG_REGION_END:   cfg.region_end = val[ADDR_W-1:0];
            REG_REPLY_NODE:   cfg.reply_node = val[NODE_W-1:0];
            default:          cfg.ack_count = val[ACK_W-1:0];
        endcase
    endtask

    task automatic set_config(input logic [5:0] node, input logic [47:0] rs,
                              input logic [47:0] re, input logic [5:0] home,
                              input logic [3:0] ack);
        reg_write(REG_NODE_ID, 64'(node));
        reg_write(REG_REGION_START, 64'(rs));
        reg_write(REG_REGION_END, 64'(re));
        reg_write(REG_REPLY_NODE, 64'(home));
        reg_write(REG_ACK_COUNT, 64'(ack));
    endtask

    task automatic drain();
        while (msg_q.size() > 0 || i_in_valid || outbound_q.size() > 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    function automatic t_msg mk(input logic [2:0] op, input logic [47:0] a);
        return '{op, 6'($urandom), 6'($urandom), 4'($urandom), a, rand48()};
    endfunction

    task automatic random_phase(input int n_items);
        int          kind, n, span_blk, acks;
        logic [63:0] span, off;
        foreach (atom_pool[k]) atom_pool[k] = rand48();
        span = 64'(cfg.region_end) - 64'(cfg.region_start);
        span_blk = 1100;
        n = 0;
        while (n < n_items) begin
            kind = $urandom_range(0, 99);
            acks = (cfg.ack_count == 0) ? 1 : cfg.ack_count;
            if (kind < 40) begin
                off = {$urandom, $urandom} % (64'(span_blk) << DEF_BLOCK_SHIFT);
                if (cfg.region_end > cfg.region_start && span < (64'(span_blk) << DEF_BLOCK_SHIFT))
                    off = off % (span + 2);
                msg_q.push_back(mk(OP_SHARED_REQ, 48'(64'(cfg.region_start) + off - 1)));
                n++;
            end else if (kind < 68) begin
                off = atom_pool[$urandom_range(0, 3)];
                msg_q.push_back(mk(OP_ATOMIC_REQ, off[47:0]));
                n++;
                repeat ($urandom_range(0, acks + 1)) begin
                    msg_q.push_back(mk(OP_ATOMIC_REPLY, off[47:0]));
                    n++;
                end
            end else if (kind < 70) begin
                repeat (DEF_PENDING_ENTRIES + 1) msg_q.push_back(mk(OP_ATOMIC_REQ, rand48()));
                n += DEF_PENDING_ENTRIES + 1;
            end else if (kind < 80) begin
                msg_q.push_back(mk(3'($urandom_range(OP_ATOMIC_MSG, OP_SPARE)), rand48()));
                n++;
            end else if (kind < 82) begin
                msg_q.push_back(mk(OP_INIT, rand48()));
                n++;
            end else begin
                msg_q.push_back(mk(3'($urandom), rand48()));
                n++;
            end
            while (msg_q.size() > 20) @(posedge i_clk);
        end
    endtask

    initial begin
        logic [47:0] rs, re, pa;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_in_valid = 1'b0; i_out_stall = 1'b0;
        i_opcode = '0; i_requester = '0; i_receiver = '0; i_component = '0;
        i_payload_a = '0; i_payload_b = '0;
        in_taken = 1'b0; in_gap = 0; out_gap = 0; fail_cnt = 0; no_idle = 1'b0;
        cfg = '{6'd0, 48'd0, 48'd0, REPLY_NODE_RESET, ACK_COUNT_RESET};
        foreach (sub_map[k]) sub_map[k] = 1'b0;
        foreach (pend_vld[k]) pend_vld[k] = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed
        rs = 48'h0000_1234_5678;
        re = rs + (48'd300 << DEF_BLOCK_SHIFT) + 48'h123;
        pa = 48'hABCD_0000_0040;
        set_config(6'd5, rs, re, 6'd17, 4'd3);
        msg_q.push_back('{OP_INIT, 6'd63, 6'd0, 4'd15, MASK48, 48'd0});
        msg_q.push_back('{OP_SHARED_REQ, 6'd0, 6'd63, 4'd0, rs, MASK48});
        msg_q.push_back('{OP_SHARED_REQ, 6'd1, 6'd2, 4'd3, rs + 48'd1, 48'd0});
        msg_q.push_back('{OP_SHARED_REQ, 6'd2, 6'd2, 4'd3, re - 48'd1, 48'd0});
        msg_q.push_back('{OP_SHARED_REQ, 6'd3, 6'd2, 4'd3, rs - 48'd1, 48'd7});
        msg_q.push_back('{OP_SHARED_REQ, 6'd4, 6'd2, 4'd3, re, 48'd7});
        msg_q.push_back('{OP_SHARED_REQ, 6'd5, 6'd2, 4'd3, 48'd0, 48'd7});
        msg_q.push_back('{OP_SHARED_REQ, 6'd6, 6'd2, 4'd3, MASK48, 48'd7});
        msg_q.push_back('{OP_ATOMIC_REQ, 6'd7, 6'd9, 4'd4, pa, 48'h55});
        msg_q.push_back('{OP_ATOMIC_REPLY, 6'd8, 6'd9, 4'd4, pa, 48'h1});
        msg_q.push_back('{OP_ATOMIC_REPLY, 6'd8, 6'd9, 4'd4, pa + 48'd1, 48'h2});
        msg_q.push_back('{OP_ATOMIC_REPLY, 6'd8, 6'd9, 4'd4, pa, 48'h3});
        msg_q.push_back('{OP_ATOMIC_REPLY, 6'd8, 6'd9, 4'd4, pa, 48'h4});
        msg_q.push_back('{OP_ATOMIC_MSG, 6'd10, 6'd11, 4'd12, pa, MASK48});
        msg_q.push_back('{OP_INVAL_REPLY, 6'd13, 6'd14, 4'd15, MASK48, pa});
        msg_q.push_back('{OP_OTHER, 6'd63, 6'd63, 4'd15, MASK48, MASK48});
        msg_q.push_back('{OP_SPARE, 6'd0, 6'd0, 4'd0, 48'd0, 48'd0});
        msg_q.push_back('{OP_ATOMIC_REQ, 6'd20, 6'd21, 4'd1, pa, 48'd0});
        msg_q.push_back('{OP_ATOMIC_REQ, 6'd22, 6'd23, 4'd1, pa, 48'd0});
        msg_q.push_back('{OP_ATOMIC_REPLY, 6'd24, 6'd25, 4'd1, pa, 48'd0});
        msg_q.push_back('{OP_INIT, 6'd0, 6'd0, 4'd0, 48'd0, 48'd0});
        msg_q.push_back('{OP_SHARED_REQ, 6'd1, 6'd2, 4'd3, rs + 48'd1, 48'd0});
        drain();

        random_phase(300);
        drain();

        set_config(6'd63, 48'd0, MASK48, 6'd0, 4'd15);
        no_idle = 1'b1;
        random_phase(300);
        drain();
        no_idle = 1'b0;

        set_config(6'd0, MASK48 - (48'd40 << DEF_BLOCK_SHIFT) + 48'd9, MASK48, 6'd63, 4'd0);
        random_phase(300);
        drain();

        set_config(6'd42, 48'h0000_0800_0000, 48'h0000_0800_0000 + (48'd8 << DEF_BLOCK_SHIFT),
                   6'd3, 4'd1);
        random_phase(350);
        drain();

        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule
